/* design/dcps_pkg.sv */
// Shared constants, types and command structures for the dual channel PID step.
package dcps_pkg;

  localparam int VALUE_W    = 32;
  localparam int GAIN_W     = 24;
  localparam int RATE_W     = 16;
  localparam int PERIOD_W   = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int DEF_CHANNELS = 2;

  localparam logic [GAIN_W-1:0]   GAIN_P_RST = GAIN_W'(32768);
  localparam logic [GAIN_W-1:0]   GAIN_I_RST = GAIN_W'(3277);
  localparam logic [GAIN_W-1:0]   GAIN_D_RST = GAIN_W'(66);
  localparam logic [RATE_W-1:0]   RATE_RST   = RATE_W'(100);
  localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(167772);

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_RATE   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = CFG_IDX_W'(4);

  // Shared multiplier operand and product widths.
  localparam int MUL_A_W = 35;
  localparam int MUL_B_W = 25;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int DE_W    = VALUE_W + 1;
  localparam int DR_W    = DE_W + RATE_W + 2;
  localparam int ACC_W   = PROD_W + 2;
  localparam int INC_SH  = 24;
  localparam int OUT_SH  = 16;

  typedef enum logic [2:0] {
    MUL_PERIOD,
    MUL_RATE,
    MUL_PROP,
    MUL_DLO,
    MUL_DHI,
    MUL_INT
  } mul_op_e;

  typedef struct packed {
    logic    load;
    logic    err;
    logic    mul_go;
    mul_op_e mul_op;
    logic    fin;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_stat_t;

endpackage

/* design/dcps_ctrl.sv */
// Sequencing state machine that steps one word through the shared multiplier.
module dcps_ctrl import dcps_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ERR   = 4'd1;
  localparam logic [3:0] S_MPER  = 4'd2;
  localparam logic [3:0] S_MRATE = 4'd3;
  localparam logic [3:0] S_MPROP = 4'd4;
  localparam logic [3:0] S_MDLO  = 4'd5;
  localparam logic [3:0] S_MDHI  = 4'd6;
  localparam logic [3:0] S_MINT  = 4'd7;
  localparam logic [3:0] S_DRAIN = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cmd_o.mul_op = MUL_PERIOD;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_ERR;
        end
      end
      S_ERR: begin
        cmd_o.err = 1'b1;
        state_d   = S_MPER;
      end
      S_MPER: begin
        cmd_o.mul_go = 1'b1;
        cmd_o.mul_op = MUL_PERIOD;
        state_d      = S_MRATE;
      end
      S_MRATE: begin
        cmd_o.mul_go = 1'b1;
        cmd_o.mul_op = MUL_RATE;
        state_d      = S_MPROP;
      end
      S_MPROP: begin
        cmd_o.mul_go = 1'b1;
        cmd_o.mul_op = MUL_PROP;
        state_d      = S_MDLO;
      end
      S_MDLO: begin
        cmd_o.mul_go = 1'b1;
        cmd_o.mul_op = MUL_DLO;
        state_d      = S_MDHI;
      end
      S_MDHI: begin
        cmd_o.mul_go = 1'b1;
        cmd_o.mul_op = MUL_DHI;
        state_d      = S_MINT;
      end
      S_MINT: begin
        cmd_o.mul_go = 1'b1;
        cmd_o.mul_op = MUL_INT;
        state_d      = S_DRAIN;
      end
      S_DRAIN: begin
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!stat_i.out_busy) begin
          cmd_o.fin = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* design/dcps_datapath.sv */
// Datapath with configuration registers, channel state, shared multiplier and output register.
module dcps_datapath import dcps_pkg::*; #(
  parameter int CHANNELS = DEF_CHANNELS,
  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dp_cmd_t                      cmd_i,
  output dp_stat_t                     stat_o,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                         kind_i,
  input  logic signed [VALUE_W-1:0]    setpoint_i,
  input  logic signed [VALUE_W-1:0]    measured_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [VALUE_W-1:0]    drive_o,
  output logic                         integral_cleared_o,
  output logic                         saturated_o
);

  localparam logic signed [VALUE_W-1:0] MAXV = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] MINV = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam int INC_W = PROD_W - INC_SH;
  localparam int FIN_W = PROD_W + 1;

  logic signed [GAIN_W-1:0]   gain_p_q, gain_i_q, gain_d_q;
  logic [RATE_W-1:0]          rate_q;
  logic [PERIOD_W-1:0]        period_q;

  logic signed [VALUE_W-1:0]  sp_q, ms_q, e_q, integ_q;
  logic [CH_W-1:0]            ch_q;
  logic                       neg_q, clr_q;
  logic signed [DE_W-1:0]     de_q;
  logic signed [VALUE_W-1:0]  last_q [CHANNELS];
  logic signed [VALUE_W-1:0]  int_q  [CHANNELS];
  logic signed [PROD_W-1:0]   prod_q, hi_q;
  mul_op_e                    pop_q;
  logic                       pvld_q;
  logic signed [DR_W-1:0]     dr_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic                       out_valid_q;
  logic signed [VALUE_W-1:0]  drive_q;
  logic                       clr_out_q, sat_q;

  logic [CH_W:0]              kind_ext;
  logic [CH_W-1:0]            ch_sel;
  logic signed [VALUE_W:0]    diff;
  logic signed [VALUE_W-1:0]  e_sat;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]   product;
  logic signed [PROD_W-1:0]   inc_sum;
  logic signed [INC_W:0]      int_sum;
  logic signed [VALUE_W-1:0]  integ_sat;
  logic                       clear_hit;
  logic signed [FIN_W-1:0]    fin_sum;
  logic signed [FIN_W:0]      fin_val;
  logic                       fin_ovf;
  logic signed [VALUE_W-1:0]  fin_clip;

  assign kind_ext = (CH_W+1)'(kind_i);
  assign ch_sel   = (kind_ext >= (CH_W+1)'(CHANNELS)) ? CH_W'(CHANNELS - 1)
                                                      : kind_ext[CH_W-1:0];

  assign diff  = {sp_q[VALUE_W-1], sp_q} - {ms_q[VALUE_W-1], ms_q};
  assign e_sat = (diff[VALUE_W] != diff[VALUE_W-1]) ?
                 (diff[VALUE_W] ? MINV : MAXV) : diff[VALUE_W-1:0];

  always_comb begin
    case (cmd_i.mul_op)
      MUL_PERIOD: begin
        mul_a = MUL_A_W'(e_q);
        mul_b = $signed({{(MUL_B_W-PERIOD_W){1'b0}}, period_q});
      end
      MUL_RATE: begin
        mul_a = MUL_A_W'(de_q);
        mul_b = $signed({{(MUL_B_W-RATE_W){1'b0}}, rate_q});
      end
      MUL_PROP: begin
        mul_a = MUL_A_W'(e_q);
        mul_b = MUL_B_W'(gain_p_q);
      end
      MUL_DLO: begin
        mul_a = $signed({{(MUL_A_W-OUT_SH){1'b0}}, dr_q[OUT_SH-1:0]});
        mul_b = MUL_B_W'(gain_d_q);
      end
      MUL_DHI: begin
        mul_a = MUL_A_W'(dr_q[DR_W-1:OUT_SH]);
        mul_b = MUL_B_W'(gain_d_q);
      end
      MUL_INT: begin
        mul_a = MUL_A_W'(integ_q);
        mul_b = MUL_B_W'(gain_i_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign product = mul_a * mul_b;

  // Integral update: round the increment to Q16.16, add, saturate, then test for clearing.
  assign inc_sum = prod_q + PROD_W'(64'sd1 <<< (INC_SH - 1));
  assign int_sum = (INC_W+1)'(int_q[ch_q]) + (INC_W+1)'($signed(inc_sum[PROD_W-1:INC_SH]));
  always_comb begin
    if (int_sum > (INC_W+1)'(MAXV)) begin
      integ_sat = MAXV;
    end else if (int_sum < (INC_W+1)'(MINV)) begin
      integ_sat = MINV;
    end else begin
      integ_sat = int_sum[VALUE_W-1:0];
    end
  end
  assign clear_hit = $signed({integ_sat, 1'b0}) > $signed({sp_q[VALUE_W-1], sp_q});

  assign fin_sum = FIN_W'($signed(acc_q[ACC_W-1:OUT_SH])) + FIN_W'(hi_q);
  assign fin_val = neg_q ? -(FIN_W+1)'(fin_sum) : (FIN_W+1)'(fin_sum);
  assign fin_ovf = (fin_val > (FIN_W+1)'(MAXV)) || (fin_val < (FIN_W+1)'(MINV));
  assign fin_clip = (fin_val > (FIN_W+1)'(MAXV)) ? MAXV :
                    (fin_val < (FIN_W+1)'(MINV)) ? MINV : fin_val[VALUE_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q <= GAIN_P_RST;
      gain_i_q <= GAIN_I_RST;
      gain_d_q <= GAIN_D_RST;
      rate_q   <= RATE_RST;
      period_q <= PERIOD_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_GAIN_P: gain_p_q <= cfg_data_i[GAIN_W-1:0];
        REG_GAIN_I: gain_i_q <= cfg_data_i[GAIN_W-1:0];
        REG_GAIN_D: gain_d_q <= cfg_data_i[GAIN_W-1:0];
        REG_RATE:   rate_q   <= cfg_data_i[RATE_W-1:0];
        REG_PERIOD: period_q <= cfg_data_i[PERIOD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        last_q[i] <= '0;
        int_q[i]  <= '0;
      end
      pvld_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pvld_q <= cmd_i.mul_go;
      if (cmd_i.mul_go && (cmd_i.mul_op == MUL_PERIOD)) begin
        last_q[ch_q] <= e_q;
      end
      if (pvld_q && (pop_q == MUL_PERIOD)) begin
        int_q[ch_q] <= clear_hit ? '0 : integ_sat;
      end
      if (cmd_i.fin) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sp_q  <= setpoint_i;
      ms_q  <= measured_i;
      ch_q  <= ch_sel;
      neg_q <= (ch_sel == '0);
    end
    if (cmd_i.err) begin
      e_q <= e_sat;
    end
    if (cmd_i.mul_go) begin
      prod_q <= product;
      pop_q  <= cmd_i.mul_op;
      if (cmd_i.mul_op == MUL_PERIOD) begin
        de_q <= DE_W'(e_q) - DE_W'(last_q[ch_q]);
      end
    end
    if (pvld_q) begin
      case (pop_q)
        MUL_PERIOD: begin
          integ_q <= clear_hit ? '0 : integ_sat;
          clr_q   <= clear_hit;
        end
        MUL_RATE: dr_q  <= prod_q[DR_W-1:0];
        MUL_PROP: acc_q <= ACC_W'(prod_q) + ACC_W'(64'sd1 <<< (OUT_SH - 1));
        MUL_DLO:  acc_q <= acc_q + ACC_W'(prod_q);
        MUL_DHI:  hi_q  <= prod_q;
        MUL_INT:  acc_q <= acc_q + ACC_W'(prod_q);
        default: begin
        end
      endcase
    end
    if (cmd_i.fin) begin
      drive_q   <= fin_clip;
      clr_out_q <= clr_q;
      sat_q     <= fin_ovf;
    end
  end

  assign stat_o.out_busy    = out_valid_q && !out_ready_i;
  assign out_valid_o        = out_valid_q;
  assign drive_o            = drive_q;
  assign integral_cleared_o = clr_out_q;
  assign saturated_o        = sat_q;

endmodule

/* design/dual_channel_pid_step.sv */
// Top level of the dual channel PID step: controller plus datapath.
// The result word is registered in the finish state, which follows the error, six multiply and drain states.
// A new word is accepted only once the last one has made its six passes through one shared multiplier.
// The output register lets a new word be accepted while the previous result waits.
// Reset is asynchronous and active low; it restores the gains and clears both channels' state.
module dual_channel_pid_step import dcps_pkg::*; #(
  parameter int CHANNELS = DEF_CHANNELS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      kind_i,
  input  logic signed [VALUE_W-1:0] setpoint_i,
  input  logic signed [VALUE_W-1:0] measured_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [VALUE_W-1:0] drive_o,
  output logic                      integral_cleared_o,
  output logic                      saturated_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  dcps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dcps_datapath #(
    .CHANNELS (CHANNELS)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .kind_i             (kind_i),
    .setpoint_i         (setpoint_i),
    .measured_i         (measured_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .drive_o            (drive_o),
    .integral_cleared_o (integral_cleared_o),
    .saturated_o        (saturated_o)
  );

endmodule

/* dv/tb_dual_channel_pid_step.sv */
`timescale 1ns / 1ps
// Self-checking testbench: random and corner words, gain settings, drive scoreboard.
module tb_dual_channel_pid_step;
  import dcps_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 12;
  localparam int PHASES       = 10;
  localparam int PHASE_WORDS  = 125;
  localparam int PRESSURE_PHASE = 5;

  localparam longint VMAX_L = (longint'(1) <<< (VALUE_W - 1)) - 1;
  localparam longint VMIN_L = -VMAX_L - 1;
  localparam logic signed [VALUE_W-1:0] VMAX = VALUE_W'(VMAX_L);
  localparam logic signed [VALUE_W-1:0] VMIN = VALUE_W'(VMIN_L);
  localparam logic [GAIN_W-1:0] GAIN_MAX = {1'b0, {(GAIN_W-1){1'b1}}};
  localparam logic [GAIN_W-1:0] GAIN_MIN = {1'b1, {(GAIN_W-1){1'b0}}};
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = REG_PERIOD + CFG_IDX_W'(1);

  typedef struct {
    logic signed [VALUE_W-1:0] drive;
    logic                      cleared;
    logic                      sat;
  } drive_rec_t;

  class pid_drive_board;
    longint     gain_p, gain_i, gain_d, rate, period;
    longint     last_err[DEF_CHANNELS];
    longint     integral[DEF_CHANNELS];
    drive_rec_t pending_drives[$];
    int         errors, results, cleared_seen, clipped_seen;

    function new();
      gain_p = longint'(signed'(GAIN_P_RST));
      gain_i = longint'(signed'(GAIN_I_RST));
      gain_d = longint'(signed'(GAIN_D_RST));
      rate   = longint'(RATE_RST);
      period = longint'(PERIOD_RST);
      foreach (last_err[c]) begin
        last_err[c] = 0;
        integral[c] = 0;
      end
      errors = 0;
      results = 0;
      cleared_seen = 0;
      clipped_seen = 0;
    endfunction

    function longint clamp(longint v, inout bit hit);
      if (v > VMAX_L) begin
        hit = 1'b1;
        return VMAX_L;
      end
      if (v < VMIN_L) begin
        hit = 1'b1;
        return VMIN_L;
      end
      return v;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_GAIN_P: gain_p = longint'(signed'(data[GAIN_W-1:0]));
        REG_GAIN_I: gain_i = longint'(signed'(data[GAIN_W-1:0]));
        REG_GAIN_D: gain_d = longint'(signed'(data[GAIN_W-1:0]));
        REG_RATE:   rate = longint'(data[RATE_W-1:0]);
        REG_PERIOD: period = longint'(data[PERIOD_W-1:0]);
        default: ;
      endcase
    endfunction

    function void note_input(logic k, logic signed [VALUE_W-1:0] sp,
                             logic signed [VALUE_W-1:0] ms);
      longint     spl, e, integ, de, dr, hi, lo, acc, drv;
      bit         dummy, sat;
      int         ch;
      drive_rec_t want;
      ch = (int'(k) < DEF_CHANNELS) ? int'(k) : DEF_CHANNELS - 1;
      spl = longint'(sp);
      dummy = 1'b0;
      sat = 1'b0;
      e = clamp(spl - longint'(ms), dummy);
      integ = integral[ch] + ((e * period + (longint'(1) <<< 23)) >>> INC_SH);
      integ = clamp(integ, dummy);
      want.cleared = 1'b0;
      if (2 * integ > spl) begin
        integ = 0;
        want.cleared = 1'b1;
      end
      integral[ch] = integ;
      de = e - last_err[ch];
      last_err[ch] = e;
      dr = de * rate;
      // Split the derivative product so the gain multiply stays within 64 bits.
      hi = dr >>> 16;
      lo = dr - (hi <<< 16);
      acc = gain_p * e + gain_i * integ + gain_d * lo + (longint'(1) <<< 15);
      drv = gain_d * hi + (acc >>> OUT_SH);
      if (ch == 0) drv = -drv;
      drv = clamp(drv, sat);
      want.drive = VALUE_W'(drv);
      want.sat = sat;
      pending_drives = {pending_drives, want};
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= 10) $display("ERROR: %s", msg);
    endfunction

    function void check_drive(logic signed [VALUE_W-1:0] drive, logic cleared, logic sat);
      drive_rec_t want;
      results++;
      if (pending_drives.size() == 0) begin
        note_error($sformatf("result %0d arrived with nothing pending: drive %0d",
                             results, drive));
        return;
      end
      want = pending_drives.pop_front();
      if (want.cleared) cleared_seen++;
      if (want.sat) clipped_seen++;
      if (drive !== want.drive)
        note_error($sformatf("result %0d drive: expected %0d, got %0d",
                             results, want.drive, drive));
      if (cleared !== want.cleared)
        note_error($sformatf("result %0d integral_cleared: expected %0b, got %0b",
                             results, want.cleared, cleared));
      if (sat !== want.sat)
        note_error($sformatf("result %0d saturated: expected %0b, got %0b",
                             results, want.sat, sat));
    endfunction

    function void flag_leftovers();
      if (pending_drives.size() != 0)
        note_error($sformatf("%0d expected results never arrived", pending_drives.size()));
    endfunction
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]     cfg_data_i = '0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic                      kind_i = 1'b0;
  logic signed [VALUE_W-1:0] setpoint_i = '0;
  logic signed [VALUE_W-1:0] measured_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic signed [VALUE_W-1:0] drive_o;
  logic                      integral_cleared_o;
  logic                      saturated_o;

  pid_drive_board board = new();
  bit  idle_on = 1'b1;
  int  stall_left = 0;
  int  cycles = 0;
  int  words_sent = 0;
  int  cfg_writes = 0;

  dual_channel_pid_step dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .kind_i             (kind_i),
    .setpoint_i         (setpoint_i),
    .measured_i         (measured_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .drive_o            (drive_o),
    .integral_cleared_o (integral_cleared_o),
    .saturated_o        (saturated_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_drive(drive_o, integral_cleared_o, saturated_o);
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 9) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d results pending.",
               cycles, board.pending_drives.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Valid stays high across back-to-back words and is lowered only for a gap or a drain.
  task automatic send_word(input logic k, input logic signed [VALUE_W-1:0] sp,
                           input logic signed [VALUE_W-1:0] ms);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= k;
    setpoint_i <= sp;
    measured_i <= ms;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_input(k, sp, ms);
    words_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending_drives.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    board.write_reg(idx, data);
    cfg_writes++;
  endtask

  function automatic logic [GAIN_W-1:0] rand_gain();
    if ($urandom_range(0, 1) == 0) return GAIN_W'($urandom);
    return GAIN_W'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
  endfunction

  function automatic logic signed [VALUE_W-1:0] corner_value();
    case ($urandom_range(0, 5))
      0: return VMAX;
      1: return VMIN;
      2: return '0;
      3: return 1;
      4: return -1;
      default: return $urandom;
    endcase
  endfunction

  task automatic program_phase(input int phase);
    logic [GAIN_W-1:0]   gp, gi, gd;
    logic [RATE_W-1:0]   rt;
    logic [PERIOD_W-1:0] pr;
    case (phase)
      1: begin
        gp = GAIN_MAX;
        gi = GAIN_MAX;
        gd = GAIN_MAX;
        rt = '1;
        pr = '1;
      end
      2: begin
        gp = GAIN_MIN;
        gi = GAIN_MIN;
        gd = GAIN_MIN;
        rt = '0;
        pr = '0;
      end
      3: begin
        gp = GAIN_P_RST;
        gi = GAIN_I_RST;
        gd = GAIN_D_RST;
        rt = RATE_RST;
        pr = PERIOD_RST;
      end
      default: begin
        gp = rand_gain();
        gi = rand_gain();
        gd = rand_gain();
        rt = ($urandom_range(0, 3) == 0) ? RATE_W'($urandom_range(0, 15)) : RATE_W'($urandom);
        pr = ($urandom_range(0, 1) == 0) ? PERIOD_W'($urandom)
                                         : PERIOD_W'($urandom_range(0, 1 << 20));
      end
    endcase
    cfg_write(REG_GAIN_P, gp);
    cfg_write(REG_GAIN_I, gi);
    cfg_write(REG_GAIN_D, gd);
    cfg_write(REG_RATE, {(CFG_DATA_W-RATE_W)'($urandom), rt});
    cfg_write(REG_PERIOD, pr);
    cfg_write(REG_SPARE_LO + CFG_IDX_W'($urandom_range(0, 2)), CFG_DATA_W'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  // Half the words look like a settling loop: moderate setpoints, small errors.
  task automatic send_random_word();
    logic                      k;
    logic signed [VALUE_W-1:0] sp, ms;
    int                        mode;
    k = 1'($urandom_range(0, 1));
    mode = $urandom_range(0, 7);
    if (mode < 4) begin
      sp = int'($urandom_range(0, 1 << 21)) - (1 << 20);
      ms = sp - (int'($urandom_range(0, 1 << 17)) - (1 << 16));
    end else if (mode < 6) begin
      sp = $urandom;
      ms = $urandom;
    end else begin
      sp = corner_value();
      ms = corner_value();
    end
    send_word(k, sp, ms);
  endtask

  initial begin
    int waited;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    send_word(1'b0, '0, '0);
    send_word(1'b1, '0, '0);
    send_word(1'b0, VMAX, VMIN);
    send_word(1'b1, VMAX, VMIN);
    send_word(1'b0, VMIN, VMAX);
    send_word(1'b1, VMIN, VMAX);
    send_word(1'b1, VMAX, VMAX);
    send_word(1'b0, VMIN, VMIN);
    send_word(1'b1, -32'sd65536, -32'sd65536);
    send_word(1'b0, -32'sd1, 32'sd0);
    send_word(1'b1, 32'sd1, 32'sd0);
    send_word(1'b1, 32'sd65536, 32'sd0);
    send_word(1'b1, 32'sd65536, 32'sd0);
    send_word(1'b0, 32'sd131072, 32'sd65536);
    send_word(1'b0, VMAX, '0);
    send_word(1'b1, '0, VMIN);
    send_word(1'b0, 32'h5555_5555, 32'hAAAA_AAAA);
    send_word(1'b1, 32'hAAAA_AAAA, 32'h5555_5555);

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        drain();
        program_phase(phase);
      end
      idle_on = (phase != PHASES - 1);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (phase == PRESSURE_PHASE && n == PHASE_WORDS / 2) drain();
        send_random_word();
      end
    end
    in_valid_i <= 1'b0;

    waited = 0;
    while (board.pending_drives.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    board.flag_leftovers();

    $display("Sent %0d words across %0d gain settings with %0d register writes.",
             words_sent, PHASES, cfg_writes);
    $display("Checked %0d results: %0d with the integral cleared, %0d with the drive clipped.",
             board.results, board.cleared_seen, board.clipped_seen);
    if (board.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches in total.", board.errors);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
